FILE: hdl/bitmap_run_allocator_unit_macros.svh
// Assertion macros shared by the bitmap run allocator RTL.
// Users must provide clk and rst in scope.
`ifndef BITMAP_RUN_ALLOCATOR_UNIT_MACROS_SVH
`define BITMAP_RUN_ALLOCATOR_UNIT_MACROS_SVH

// Checked on every clock, quiet while reset is high.
`define BRA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock, including during reset.
`define BRA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/bra_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the bitmap run allocator.
// No dependencies.
package bra_pkg;

  localparam int CMD_W = 3;
  localparam int IDX_W = 10;
  localparam int RUN_W = 11;
  localparam int ULEN_W = 11;

  // Map size; the field widths above are sized for it.
  localparam int MAX_BITS = 1024;

  localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 3'd0;
  localparam logic [CMD_W-1:0] CMD_TEST      = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SET       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SCAN      = 3'd4;

  localparam logic [7:0] BYTE_FULL = 8'hff;

  typedef struct packed {
    logic start;
    logic step;
  } scan_ctrl_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [IDX_W-1:0] start_index;
  } scan_stat_t;

endpackage

FILE: hdl/bra_channels.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for commands and results.
// Depends on bra_pkg.
interface bra_in_if import bra_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [IDX_W-1:0] bit_index;
  logic [RUN_W-1:0] run_length;

  modport source(output valid, command, bit_index, run_length, input ready);
  modport sink(input valid, command, bit_index, run_length, output ready);
endinterface

interface bra_out_if import bra_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             bit_value;
  logic             found;
  logic [IDX_W-1:0] start_index;
  logic             index_error;

  modport source(output valid, bit_value, found, start_index, index_error, input ready);
  modport sink(input valid, bit_value, found, start_index, index_error, output ready);
endinterface

FILE: hdl/bitmap_run_allocator_unit.sv
`timescale 1ns / 1ps
// Accept to result valid: test/set/clear pass ST_RMW, then ST_FIN; index error, zero run
// length and spare commands go to ST_FIN; scan reads bytes (one per cycle, at least one,
// at most ceil(len/8), stops on the first hit), then ST_FIN; clear all zeroes every byte,
// then ST_FIN. A full output adds wait. One command in flight, byte RAM with one read and
// one write port; the next command can be taken in the cycle after the result is loaded.
// Reset (synchronous) zeroes the RAM with ready low; used_length resets to 1024.
// Depends on bra_pkg, bra_channels, bra_scan and the assertion macro header.
`include "bitmap_run_allocator_unit_macros.svh"

module bitmap_run_allocator_unit import bra_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [ULEN_W-1:0] cfg_wdata,
  bra_in_if.sink            in_ch,
  bra_out_if.source         out_ch
);

  localparam int DEPTH = (MAX_BITS + 7) / 8;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW = $clog2(MAX_BITS + 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RMW  = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_CLR  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]        state;
  logic              boot;
  logic [ULEN_W-1:0] used_length;
  logic [CMD_W-1:0]  cmd_q;
  logic [IDX_W-1:0]  idx_q;
  logic [RUN_W-1:0]  run_q;
  logic [AW-1:0]     clr_addr;
  logic [AW-1:0]     scan_addr;
  logic              res_bit;
  logic              res_found;
  logic [IDX_W-1:0]  res_start;
  logic              res_err;
  logic              out_valid;
  logic              out_bit;
  logic              out_found;
  logic [IDX_W-1:0]  out_start;
  logic              out_err;

  logic [7:0]        mem [DEPTH];
  logic [7:0]        rdata;
  logic [AW-1:0]     raddr;
  logic              mem_we;
  logic [AW-1:0]     waddr;
  logic [7:0]        wdata;

  logic [LW-1:0]     len;
  logic              accept;
  logic              idx_bad;
  logic              out_free;
  logic [7:0]        bit_mask;
  scan_ctrl_t        scan_ctrl;
  scan_stat_t        scan_stat;

  assign len = (32'(used_length) > 32'(MAX_BITS)) ? LW'(MAX_BITS) : LW'(used_length);
  assign in_ch.ready = (state == ST_IDLE);
  assign accept = in_ch.valid && in_ch.ready;
  assign idx_bad = 32'(in_ch.bit_index) >= 32'(len);
  assign out_free = !out_valid || out_ch.ready;
  assign bit_mask = 8'b1 << idx_q[2:0];

  // Byte RAM, one read and one write port, registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    raddr  = AW'(idx_q >> 3);
    mem_we = 1'b0;
    waddr  = AW'(idx_q >> 3);
    wdata  = rdata & ~bit_mask;
    case (state)
      ST_IDLE: begin
        raddr = (in_ch.command == CMD_SCAN) ? '0 : AW'(in_ch.bit_index >> 3);
      end
      ST_SCAN: begin
        raddr = scan_addr;
      end
      ST_RMW: begin
        if (cmd_q == CMD_SET) begin
          mem_we = 1'b1;
          wdata  = rdata | bit_mask;
        end else if (cmd_q == CMD_CLEAR) begin
          mem_we = 1'b1;
        end
      end
      ST_CLR: begin
        mem_we = 1'b1;
        waddr  = clr_addr;
        wdata  = '0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign scan_ctrl.start = accept && (in_ch.command == CMD_SCAN);
  assign scan_ctrl.step  = (state == ST_SCAN);

  bra_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (scan_ctrl),
    .byte_data  (rdata),
    .run_length (run_q),
    .len        (len),
    .stat       (scan_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      used_length <= ULEN_W'(1024);
    end else if (cfg_we) begin
      used_length <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      boot      <= 1'b1;
      clr_addr  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cmd_q     <= in_ch.command;
            idx_q     <= in_ch.bit_index;
            run_q     <= in_ch.run_length;
            res_bit   <= 1'b0;
            res_found <= 1'b0;
            res_start <= '0;
            res_err   <= 1'b0;
            case (in_ch.command)
              CMD_CLEAR_ALL: begin
                clr_addr <= '0;
                boot     <= 1'b0;
                state    <= ST_CLR;
              end
              CMD_TEST, CMD_SET, CMD_CLEAR: begin
                if (idx_bad) begin
                  res_err <= 1'b1;
                  state   <= ST_FIN;
                end else begin
                  state <= ST_RMW;
                end
              end
              CMD_SCAN: begin
                scan_addr <= AW'(1);
                state     <= (in_ch.run_length == '0) ? ST_FIN : ST_SCAN;
              end
              default: begin
                state <= ST_FIN;
              end
            endcase
          end
        end
        ST_RMW: begin
          if (cmd_q == CMD_TEST) begin
            res_bit <= rdata[idx_q[2:0]];
          end
          state <= ST_FIN;
        end
        ST_SCAN: begin
          scan_addr <= scan_addr + 1'b1;
          if (scan_stat.done) begin
            res_found <= scan_stat.found;
            res_start <= scan_stat.start_index;
            state     <= ST_FIN;
          end
        end
        ST_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= boot ? ST_IDLE : ST_FIN;
            boot  <= 1'b0;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_bit   <= res_bit;
            out_found <= res_found;
            out_start <= res_start;
            out_err   <= res_err;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.bit_value   = out_bit;
  assign out_ch.found       = out_found;
  assign out_ch.start_index = out_start;
  assign out_ch.index_error = out_err;

  `BRA_ASSERT(a_accept_leaves_idle, accept |=> (state != ST_IDLE), "accepted command left FSM idle")
  `BRA_ASSERT(a_result_from_fin, $rose(out_valid) |-> ($past(state) == ST_FIN), "result loaded outside finish")
  `BRA_ASSERT(a_flags_exclusive, out_valid |-> !((out_found || out_bit) && out_err), "error flagged with data")
  `BRA_ASSERT(a_scan_no_write, (state == ST_SCAN) |-> !mem_we, "map written during scan")
  `BRA_ASSERT_ALWAYS(a_reset_busy, rst |=> !in_ch.ready, "ready during reset clear")

endmodule

FILE: hdl/bra_scan.sv
`timescale 1ns / 1ps
// Free-run scanner: consumes one map byte per step, tracks the zero run.
// Depends on bra_pkg.
module bra_scan import bra_pkg::*; (
  input  logic                                clk,
  input  logic                                rst,
  input  scan_ctrl_t                          ctrl,
  input  logic [7:0]                          byte_data,
  input  logic [RUN_W-1:0]                    run_length,
  input  logic [$clog2(MAX_BITS+1)-1:0]       len,
  output scan_stat_t                          stat
);

  localparam int DEPTH = (MAX_BITS + 7) / 8;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [RUN_W-1:0] count;
  logic [AW-1:0]    bpos;
  logic [RUN_W-1:0] count_next;
  logic             hit;
  logic [IDX_W-1:0] hit_start;
  logic             last_byte;

  // Walk the eight bits of the current byte, lowest first.
  always_comb begin
    logic [RUN_W-1:0] cnt;
    logic             fnd;
    logic [IDX_W-1:0] st;
    logic [AW+2:0]    kk;
    cnt = count;
    fnd = 1'b0;
    st  = '0;
    kk  = '0;
    if (byte_data == BYTE_FULL) begin
      cnt = '0;
    end else begin
      for (int i = 0; i < 8; i++) begin
        kk = {bpos, 3'(i)};
        if (!fnd && (32'(kk) < 32'(len))) begin
          if (byte_data[i]) begin
            cnt = '0;
          end else begin
            cnt = cnt + 1'b1;
          end
          if (cnt == run_length) begin
            fnd = 1'b1;
            st  = IDX_W'(32'(kk) + 32'd1 - 32'(run_length));
          end
        end
      end
    end
    count_next = cnt;
    hit        = fnd;
    hit_start  = st;
  end

  assign last_byte = (32'({bpos, 3'b111}) + 32'd1) >= 32'(len);

  assign stat.done        = ctrl.step && (hit || last_byte);
  assign stat.found       = hit;
  assign stat.start_index = hit ? hit_start : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      bpos  <= '0;
    end else if (ctrl.start) begin
      count <= '0;
      bpos  <= '0;
    end else if (ctrl.step) begin
      count <= count_next;
      bpos  <= bpos + 1'b1;
    end
  end

endmodule

FILE: dv/bra_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the bitmap run allocator: snoops both channels and the config port,
// predicts every result from its own copy of the map and compares. Depends on bra_pkg, bra_channels.
module bra_checker import bra_pkg::*; #(
  parameter int MAP_BITS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [ULEN_W-1:0] cfg_wdata,
  bra_in_if                 cmd_mon,
  bra_out_if                rsp_mon,
  output int                fail_count,
  output int                pending,
  output int                result_count,
  output int                found_count
);

  typedef struct packed {
    logic             bit_value;
    logic             found;
    logic [IDX_W-1:0] start_index;
    logic             index_error;
  } alloc_result_t;

  logic [MAP_BITS-1:0] alloc_map;
  logic [ULEN_W-1:0]   used_len;
  alloc_result_t       expected_q[$];

  // Applies one command to the shadow map and returns what the block must report.
  function automatic alloc_result_t apply_command(logic [CMD_W-1:0] cmd,
                                                  logic [IDX_W-1:0] idx,
                                                  logic [RUN_W-1:0] run);
    alloc_result_t r;
    int span;
    int streak;
    r = '0;
    span = (used_len > MAP_BITS) ? MAP_BITS : int'(used_len);
    case (cmd)
      CMD_CLEAR_ALL: alloc_map = '0;
      CMD_TEST, CMD_SET, CMD_CLEAR: begin
        if (idx >= span) begin
          r.index_error = 1'b1;
        end else if (cmd == CMD_TEST) begin
          r.bit_value = alloc_map[idx];
        end else begin
          alloc_map[idx] = (cmd == CMD_SET);
        end
      end
      CMD_SCAN: begin
        // first fit: lowest run of free bits wholly inside the used length
        if (run != 0) begin
          streak = 0;
          for (int k = 0; k < span; k++) begin
            streak = alloc_map[k] ? 0 : streak + 1;
            if (streak == run) begin
              r.found = 1'b1;
              r.start_index = IDX_W'(k + 1 - streak);
              break;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    alloc_result_t got;
    alloc_result_t want;
    if (rst) begin
      alloc_map = '0;
      used_len = ULEN_W'(MAP_BITS);
      expected_q.delete();
      fail_count = 0;
      result_count = 0;
      found_count = 0;
    end else begin
      if (cfg_we) used_len = cfg_wdata;
      if (cmd_mon.valid && cmd_mon.ready)
        expected_q.push_back(apply_command(cmd_mon.command, cmd_mon.bit_index,
                                           cmd_mon.run_length));
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = {rsp_mon.bit_value, rsp_mon.found, rsp_mon.start_index, rsp_mon.index_error};
        result_count++;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected transaction, expected none, actual %h", $time, got);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (want.found) found_count++;
          check_field("bit_value", int'(want.bit_value), int'(got.bit_value));
          check_field("found", int'(want.found), int'(got.found));
          check_field("start_index", int'(want.start_index), int'(got.start_index));
          check_field("index_error", int'(want.index_error), int'(got.index_error));
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// Top of the bitmap run allocator bench: clock, reset, command stimulus, result back-pressure
// and the verdict. Depends on bra_pkg, bra_channels, bra_checker and the allocator RTL.
module tb_top;
  import bra_pkg::*;

  localparam int MAP_BITS     = 1024;
  localparam int DRAIN_CYCLES = 140;
  localparam int STALL_LIMIT  = 5000;
  localparam int LONG_HOLD    = 400;
  localparam int N_PHASES     = 8;
  localparam int PHASE_ITEMS  = 175;
  localparam int HOLD_PHASE   = 3;
  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [ULEN_W-1:0] cfg_wdata = '0;
  logic [ULEN_W-1:0] cur_len = ULEN_W'(MAP_BITS);
  logic              hold_req = 1'b0;

  int fail_count;
  int pending;
  int result_count;
  int found_count;
  int src_gap_pct = 30;
  int sink_gap_pct = 30;
  int idle_cycles = 0;
  int sent = 0;
  int phase_len[N_PHASES] = '{1024, 2047, 37, 1024, 1, 200, 1024, 1024};

  bra_in_if  cmd_ch ();
  bra_out_if rsp_ch ();

  always #5 clk = ~clk;

  bitmap_run_allocator_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (cmd_ch),
    .out_ch    (rsp_ch)
  );

  bra_checker #(.MAP_BITS(MAP_BITS)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd_mon      (cmd_ch),
    .rsp_mon      (rsp_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count),
    .found_count  (found_count)
  );

  // watchdog: cycles without any transaction or register write
  always @(posedge clk) begin
    if (rst || cfg_we || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stall bursts, plus one long hold-off on request
  initial begin
    int stall_left;
    bit hold_taken;
    stall_left = 0;
    hold_taken = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else if (hold_req && !hold_taken) begin
        rsp_ch.ready <= 1'b0;
        stall_left = LONG_HOLD - 1;
        hold_taken = 1'b1;
      end else if ($urandom_range(1, 100) <= sink_gap_pct) begin
        rsp_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 14);
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_cmd(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx, logic [RUN_W-1:0] run);
    int gap;
    gap = ($urandom_range(1, 100) <= src_gap_pct) ? $urandom_range(1, 15) : 0;
    repeat (gap) begin
      @(negedge clk);
      cmd_ch.valid <= 1'b0;
    end
    @(negedge clk);
    cmd_ch.valid      <= 1'b1;
    cmd_ch.command    <= cmd;
    cmd_ch.bit_index  <= idx;
    cmd_ch.run_length <= run;
    do @(posedge clk); while (!cmd_ch.ready);
    sent++;
  endtask

  // drop valid and wait until every result is back
  task automatic quiesce();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_len(logic [ULEN_W-1:0] len);
    quiesce();
    cfg_we    <= 1'b1;
    cfg_wdata <= len;
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_len = len;
  endtask

  function automatic int eff_len();
    return (cur_len > MAP_BITS) ? MAP_BITS : int'(cur_len);
  endfunction

  task automatic random_cmd();
    int eff;
    int window;
    int pick;
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    logic [RUN_W-1:0] run;
    eff = eff_len();
    window = (eff < 96) ? eff : 96;
    pick = $urandom_range(0, 99);
    if (pick < 4) cmd = CMD_CLEAR_ALL;
    else if (pick < 20) cmd = CMD_TEST;
    else if (pick < 58) cmd = CMD_SET;
    else if (pick < 70) cmd = CMD_CLEAR;
    else if (pick < 97) cmd = CMD_SCAN;
    else cmd = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    pick = $urandom_range(0, 99);
    if (eff == 0 || pick < 15) begin
      idx = IDX_W'($urandom_range(0, MAP_BITS - 1));
    end else if (pick < 22) begin
      // last bit in range or first one past it
      pick = eff - int'($urandom_range(0, 1));
      idx = IDX_W'((pick >= MAP_BITS) ? MAP_BITS - 1 : pick);
    end else if (pick < 65) begin
      idx = IDX_W'($urandom_range(0, window - 1));
    end else begin
      idx = IDX_W'($urandom_range(0, eff - 1));
    end
    pick = $urandom_range(0, 99);
    if (pick < 40) run = RUN_W'($urandom_range(1, 8));
    else if (pick < 62) run = RUN_W'($urandom_range(9, 64));
    else if (pick < 77) run = RUN_W'((eff > 0) ? $urandom_range(1, eff) : 0);
    else if (pick < 87) run = '0;
    else run = RUN_W'($urandom_range(0, 2047));
    send_cmd(cmd, idx, run);
  endtask

  // allocate a contiguous block so later scans must skip over it
  task automatic fill_block();
    int base;
    int count;
    base = $urandom_range(0, MAP_BITS - 1);
    count = $urandom_range(8, 40);
    for (int i = 0; i < count; i++)
      send_cmd(CMD_SET, IDX_W'(base + i), '0);
  endtask

  // free a stretch and ask for exactly that many bits
  task automatic punch_hole();
    int base;
    int count;
    base = (eff_len() > 0) ? $urandom_range(0, eff_len() - 1) : 0;
    count = $urandom_range(1, 24);
    for (int i = 0; i < count; i++)
      send_cmd(CMD_CLEAR, IDX_W'(base + i), '0);
    send_cmd(CMD_SCAN, '0, RUN_W'(count));
  endtask

  initial begin
    int target;
    int pick;
    cmd_ch.valid      = 1'b0;
    cmd_ch.command    = CMD_CLEAR_ALL;
    cmd_ch.bit_index  = '0;
    cmd_ch.run_length = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed: map edges, every command, run length corner cases
    send_cmd(CMD_CLEAR_ALL, '0, '0);
    send_cmd(CMD_SET, '0, '0);
    send_cmd(CMD_SET, '1, '0);
    send_cmd(CMD_TEST, '1, '0);
    send_cmd(CMD_TEST, IDX_W'(512), '0);
    send_cmd(CMD_SCAN, '0, '0);
    send_cmd(CMD_SCAN, '0, RUN_W'(1));
    send_cmd(CMD_SCAN, '0, RUN_W'(1022));
    send_cmd(CMD_SCAN, '0, RUN_W'(1023));
    send_cmd(CMD_SCAN, '1, '1);
    send_cmd(CMD_CLEAR, '1, '0);
    for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
      send_cmd(CMD_W'(c), '1, '1);
    write_len(ULEN_W'(9));
    send_cmd(CMD_SET, IDX_W'(9), '0);
    send_cmd(CMD_TEST, IDX_W'(8), '0);
    send_cmd(CMD_SCAN, '0, RUN_W'(8));
    write_len('0);
    send_cmd(CMD_TEST, '0, '0);
    send_cmd(CMD_SCAN, '0, RUN_W'(1));
    write_len('1);
    send_cmd(CMD_SCAN, '0, RUN_W'(MAP_BITS));
    send_cmd(CMD_CLEAR, '0, '0);
    send_cmd(CMD_SCAN, '0, RUN_W'(MAP_BITS));
    send_cmd(CMD_CLEAR_ALL, '0, '0);

    for (int p = 0; p < N_PHASES; p++) begin
      write_len(ULEN_W'(phase_len[p]));
      if (p == N_PHASES - 1) begin
        src_gap_pct = 0;
        sink_gap_pct = 0;
      end else begin
        src_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 45);
        sink_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 45);
      end
      if (p == HOLD_PHASE) hold_req = 1'b1;
      target = sent + PHASE_ITEMS;
      while (sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) fill_block();
        else if (pick < 9) punch_hole();
        else random_cmd();
      end
    end

    quiesce();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Covered %0d commands over %0d map lengths plus directed corners", sent, N_PHASES);
    $display("%0d results checked, %0d scans found a free run", result_count, found_count);
    if (fail_count == 0 && pending == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
